### sv/kjsu_pkg.sv
// Shared types, constants and helper functions of the keyed JSON string unescaper.
package kjsu_pkg;

  typedef enum logic [2:0] {
    PH_KEY   = 3'd0,
    PH_COLON = 3'd1,
    PH_SPACE = 3'd2,
    PH_STR   = 3'd3,
    PH_ESC   = 3'd4,
    PH_HEX   = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [2:0]  ntext;
    logic [31:0] data;
    logic        status;
    logic        found;
  } entry_t;

  localparam int FIFO_DEPTH = 4;

  localparam logic [3:0] KEY_LAST = 4'd13;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_U     = 8'h75;

  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = CH_QUOTE;
      4'd1:    c = 8'h73;
      4'd2:    c = 8'h79;
      4'd3:    c = 8'h6E;
      4'd4:    c = 8'h63;
      4'd5:    c = 8'h65;
      4'd6:    c = 8'h64;
      4'd7:    c = 8'h4C;
      4'd8:    c = 8'h79;
      4'd9:    c = 8'h72;
      4'd10:   c = 8'h69;
      4'd11:   c = 8'h63;
      4'd12:   c = 8'h73;
      4'd13:   c = CH_QUOTE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

endpackage

### sv/kjsu_front.sv
// Front end: parses document bytes and packs the decoded words of each byte into one entry.
module kjsu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        doc_byte,
  input  logic              doc_end,
  output logic              push,
  output kjsu_pkg::entry_t  entry
);

  kjsu_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  key_pos_r, key_pos_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [23:0] hex_bytes_r, hex_bytes_nxt;
  logic [11:0] cp_r, cp_nxt;
  logic        seen_r, seen_nxt;
  logic        nz_r, nz_nxt;

  logic [2:0]  ntext;
  logic [31:0] data;
  logic        found;
  logic [4:0]  hv;
  logic [15:0] code;
  logic        key_match;
  logic [3:0]  key_pos_adv;
  logic        key_done;
  logic [7:0]  esc_m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= kjsu_pkg::PH_KEY;
      key_pos_r   <= 4'd0;
      hex_cnt_r   <= 2'd0;
      hex_bytes_r <= 24'd0;
      cp_r        <= 12'd0;
      seen_r      <= 1'b0;
      nz_r        <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      key_pos_r   <= key_pos_nxt;
      hex_cnt_r   <= hex_cnt_nxt;
      hex_bytes_r <= hex_bytes_nxt;
      cp_r        <= cp_nxt;
      seen_r      <= seen_nxt;
      nz_r        <= nz_nxt;
    end
  end

  always_comb begin
    hv          = kjsu_pkg::hex_val(doc_byte);
    code        = {cp_r, hv[3:0]};
    key_match   = (key_pos_r <= kjsu_pkg::KEY_LAST) &&
                  (doc_byte == kjsu_pkg::key_char(key_pos_r));
    key_done    = key_match && (key_pos_r == kjsu_pkg::KEY_LAST);
    key_pos_adv = key_done ? 4'd0 :
                  key_match ? key_pos_r + 4'd1 :
                  (doc_byte == kjsu_pkg::CH_QUOTE) ? 4'd1 : 4'd0;

    phase_nxt     = phase_r;
    key_pos_nxt   = key_pos_r;
    hex_cnt_nxt   = hex_cnt_r;
    hex_bytes_nxt = hex_bytes_r;
    cp_nxt        = cp_r;
    seen_nxt      = seen_r;
    nz_nxt        = nz_r;
    ntext         = 3'd0;
    data          = 32'd0;
    esc_m         = doc_byte;
    found         = 1'b0;

    case (phase_r)
      kjsu_pkg::PH_KEY: begin
        if (doc_byte == kjsu_pkg::CH_NUL) begin
          phase_nxt = kjsu_pkg::PH_DONE;
        end else begin
          key_pos_nxt = key_pos_adv;
          if (key_done) phase_nxt = kjsu_pkg::PH_COLON;
        end
      end
      kjsu_pkg::PH_COLON: begin
        if (doc_byte == kjsu_pkg::CH_NUL) phase_nxt = kjsu_pkg::PH_DONE;
        else if (doc_byte == kjsu_pkg::CH_COLON) phase_nxt = kjsu_pkg::PH_SPACE;
      end
      kjsu_pkg::PH_SPACE: begin
        if (doc_byte == kjsu_pkg::CH_QUOTE) begin
          phase_nxt = kjsu_pkg::PH_STR;
        end else if (!kjsu_pkg::is_space(doc_byte)) begin
          if (doc_byte == kjsu_pkg::CH_NUL) begin
            phase_nxt = kjsu_pkg::PH_DONE;
          end else begin
            key_pos_nxt = key_pos_adv;
            phase_nxt   = key_done ? kjsu_pkg::PH_COLON : kjsu_pkg::PH_KEY;
          end
        end
      end
      kjsu_pkg::PH_STR: begin
        if (doc_byte == kjsu_pkg::CH_NUL || doc_byte == kjsu_pkg::CH_QUOTE) begin
          phase_nxt = kjsu_pkg::PH_DONE;
        end else if (doc_byte == kjsu_pkg::CH_BSL) begin
          phase_nxt = kjsu_pkg::PH_ESC;
        end else begin
          ntext = 3'd1;
          data  = {24'd0, doc_byte};
        end
      end
      kjsu_pkg::PH_ESC: begin
        phase_nxt = kjsu_pkg::PH_STR;
        case (doc_byte)
          kjsu_pkg::CH_N: esc_m = kjsu_pkg::CH_LF;
          kjsu_pkg::CH_R: esc_m = kjsu_pkg::CH_CR;
          kjsu_pkg::CH_T: esc_m = kjsu_pkg::CH_TAB;
          kjsu_pkg::CH_B: esc_m = kjsu_pkg::CH_BS;
          kjsu_pkg::CH_F: esc_m = kjsu_pkg::CH_FF;
          default:        esc_m = doc_byte;
        endcase
        if (doc_byte == kjsu_pkg::CH_U) begin
          phase_nxt     = kjsu_pkg::PH_HEX;
          hex_cnt_nxt   = 2'd0;
          hex_bytes_nxt = 24'd0;
          cp_nxt        = 12'd0;
        end else if (doc_byte == kjsu_pkg::CH_NUL) begin
          phase_nxt = kjsu_pkg::PH_DONE;
        end else begin
          ntext = 3'd1;
          data  = {24'd0, esc_m};
        end
      end
      kjsu_pkg::PH_HEX: begin
        if (!hv[4]) begin
          ntext         = {1'b0, hex_cnt_r};
          data          = {8'd0, hex_bytes_r};
          hex_cnt_nxt   = 2'd0;
          hex_bytes_nxt = 24'd0;
          cp_nxt        = 12'd0;
          phase_nxt     = kjsu_pkg::PH_STR;
          if (doc_byte == kjsu_pkg::CH_NUL || doc_byte == kjsu_pkg::CH_QUOTE) begin
            phase_nxt = kjsu_pkg::PH_DONE;
          end else if (doc_byte == kjsu_pkg::CH_BSL) begin
            phase_nxt = kjsu_pkg::PH_ESC;
          end else begin
            ntext = {1'b0, hex_cnt_r} + 3'd1;
            case (hex_cnt_r)
              2'd0:    data[7:0]   = doc_byte;
              2'd1:    data[15:8]  = doc_byte;
              2'd2:    data[23:16] = doc_byte;
              default: data[31:24] = doc_byte;
            endcase
          end
        end else if (hex_cnt_r == 2'd3) begin
          if (code < 16'h0080) begin
            ntext = 3'd1;
            data  = {24'd0, code[7:0]};
          end else if (code < 16'h0800) begin
            ntext = 3'd2;
            data  = {16'd0, 2'b10, code[5:0], 3'b110, code[10:6]};
          end else begin
            ntext = 3'd3;
            data  = {8'd0, 2'b10, code[5:0], 2'b10, code[11:6], 4'b1110, code[15:12]};
          end
          hex_cnt_nxt   = 2'd0;
          hex_bytes_nxt = 24'd0;
          cp_nxt        = 12'd0;
          phase_nxt     = kjsu_pkg::PH_STR;
        end else begin
          case (hex_cnt_r)
            2'd0:    hex_bytes_nxt[7:0]   = doc_byte;
            2'd1:    hex_bytes_nxt[15:8]  = doc_byte;
            default: hex_bytes_nxt[23:16] = doc_byte;
          endcase
          cp_nxt      = {cp_r[7:0], hv[3:0]};
          hex_cnt_nxt = hex_cnt_r + 2'd1;
        end
      end
      default: begin
      end
    endcase

    // replay held digits at end of document
    if (doc_end && phase_nxt == kjsu_pkg::PH_HEX) begin
      ntext = {1'b0, hex_cnt_nxt};
      data  = {8'd0, hex_bytes_nxt};
    end

    if (!seen_r && ntext != 3'd0) begin
      seen_nxt = 1'b1;
      nz_nxt   = data[7:0] != 8'd0;
    end

    found = seen_nxt && nz_nxt;

    if (doc_end) begin
      phase_nxt     = kjsu_pkg::PH_KEY;
      key_pos_nxt   = 4'd0;
      hex_cnt_nxt   = 2'd0;
      hex_bytes_nxt = 24'd0;
      cp_nxt        = 12'd0;
      seen_nxt      = 1'b0;
      nz_nxt        = 1'b0;
    end

    entry.ntext  = ntext;
    entry.data   = data;
    entry.status = doc_end;
    entry.found  = found;
    push         = accept && (ntext != 3'd0 || doc_end);
  end

endmodule

### sv/kjsu_fifo.sv
// Short entry queue between the parser front end and the word emitter.
module kjsu_fifo #(
  parameter int DEPTH = kjsu_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  kjsu_pkg::entry_t wdata,
  output logic             full,
  input  logic             pop,
  output kjsu_pkg::entry_t rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  kjsu_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == LAST_PTR) ? '0 : wptr_r + AW'(1);
      if (do_pop)  rptr_r <= (rptr_r == LAST_PTR) ? '0 : rptr_r + AW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

### sv/kjsu_back.sv
// Back end: walks the head entry and presents its words one at a time.
module kjsu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  kjsu_pkg::entry_t head,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [7:0]       out_text_byte,
  output logic             out_is_text,
  output logic             out_found,
  output logic             out_run_last
);

  logic [2:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       take;
  logic       is_text;

  always_comb begin
    total         = head.ntext + {2'd0, head.status};
    is_text       = idx_r < head.ntext;
    out_empty     = q_empty;
    out_is_text   = is_text;
    out_text_byte = is_text ? head.data[8*idx_r[1:0] +: 8] : 8'd0;
    out_found     = is_text ? 1'b0 : head.found;
    out_run_last  = (idx_r == total - 3'd1);
    take          = out_pop && !q_empty;
    q_pop         = take && out_run_last;
    idx_nxt       = idx_r;
    if (take) idx_nxt = out_run_last ? 3'd0 : idx_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

### sv/json_keyed_string_unescaper.sv
// Top level of the keyed JSON string unescaper: front end, entry queue and word emitter.
// A taken byte is decoded combinationally and its entry is written into the registered queue.
// Throughput: one byte per cycle while in_full is low; one word per cycle leaves on out_pop.
// A byte decoding to k words fills one entry, emitted word by word; the queue absorbs bursts.
// Reset: synchronous, active low; it clears parser state and queue pointers.
module json_keyed_string_unescaper #(
  parameter int FIFO_DEPTH = kjsu_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_doc_byte,
  input  logic       in_doc_end,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_text_byte,
  output logic       out_is_text,
  output logic       out_found,
  output logic       out_run_last
);

  kjsu_pkg::entry_t wentry, head;
  logic             f_push, q_pop, q_empty, accept;

  assign accept = in_push && !in_full;

  kjsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .doc_byte (in_doc_byte),
    .doc_end  (in_doc_end),
    .push     (f_push),
    .entry    (wentry)
  );

  kjsu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (wentry),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (head),
    .empty (q_empty)
  );

  kjsu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_text_byte (out_text_byte),
    .out_is_text   (out_is_text),
    .out_found     (out_found),
    .out_run_last  (out_run_last)
  );

endmodule

### sv/kjsu_checker.sv
// Port-level checks of the keyed JSON string unescaper and their bind.
module kjsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_push,
  input logic       in_full,
  input logic [7:0] in_doc_byte,
  input logic       in_doc_end,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_text_byte,
  input logic       out_is_text,
  input logic       out_found,
  input logic       out_run_last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("output not empty after reset");

  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_is_text) |-> (out_run_last && out_text_byte == 8'd0))
    else $error("status word malformed");

  a_text_no_found: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_is_text) |-> !out_found)
    else $error("found set on text word");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_text_byte) && $stable(out_is_text) &&
       $stable(out_run_last)))
    else $error("waiting word changed");

endmodule

bind json_keyed_string_unescaper kjsu_checker u_kjsu_checker (.*);
